// ----- src/vtsi_pkg.sv -----
// shared types and constants for the velocity time-sync interpolator
`default_nettype none
package vtsi_pkg;

    localparam int STAMP_W   = 48;
    localparam int VEL_W     = 32;
    localparam int AXES      = 6;
    localparam int ROW_W     = AXES * VEL_W;
    localparam int GAP_W     = 24;
    localparam int MAG_W     = 33;
    localparam int PROD_W    = 82;
    localparam int HALF_W    = 24;
    localparam int Q_W       = 35;
    localparam int SUM_W     = 36;
    localparam int DIV_STEPS = 41;
    localparam int CNT_W     = 6;

    localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;
    localparam logic [Q_W-1:0]   Q_LIMIT   = 35'h400000000;

    localparam logic [1:0] STATUS_STORED  = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_SYNCED  = 2'd2;
    localparam logic [1:0] STATUS_NO_SYNC = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_FIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic finish;
    } lane_ctrl_t;

endpackage
`default_nettype wire

// ----- src/vtsi_mem.sv -----
// sample storage: stamp memory and velocity row memory, two read ports each
`default_nettype none
module vtsi_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [$clog2(DEPTH)-1:0]            waddr,
    input  wire logic [vtsi_pkg::STAMP_W-1:0]        wstamp,
    input  wire logic [vtsi_pkg::ROW_W-1:0]          wvel,
    input  wire logic [$clog2(DEPTH)-1:0]            raddr0,
    input  wire logic [$clog2(DEPTH)-1:0]            raddr1,
    output logic      [vtsi_pkg::STAMP_W-1:0]        rstamp0,
    output logic      [vtsi_pkg::STAMP_W-1:0]        rstamp1,
    output logic      [vtsi_pkg::ROW_W-1:0]          rvel0,
    output logic      [vtsi_pkg::ROW_W-1:0]          rvel1
);

    logic [vtsi_pkg::STAMP_W-1:0] stamp_mem [DEPTH];
    logic [vtsi_pkg::ROW_W-1:0]   vel_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stamp_mem[waddr] <= wstamp;
            vel_mem[waddr]   <= wvel;
        end
    end

    always_ff @(posedge clk)
    begin
        rstamp0 <= stamp_mem[raddr0];
        rstamp1 <= stamp_mem[raddr1];
        rvel0   <= vel_mem[raddr0];
        rvel1   <= vel_mem[raddr1];
    end

endmodule
`default_nettype wire

// ----- src/vtsi_lane.sv -----
// one axis: split multiply, radix-4 restoring divide, saturating sum
`default_nettype none
module vtsi_lane (
    input  wire logic                              clk,
    input  wire vtsi_pkg::lane_ctrl_t              ctrl,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0] f_in,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0] g_in,
    input  wire logic [vtsi_pkg::STAMP_W-1:0]      uw,
    input  wire logic [vtsi_pkg::STAMP_W-1:0]      ud,
    input  wire logic                              neg_s,
    input  wire logic                              eq,
    output logic signed [vtsi_pkg::VEL_W-1:0]      res
);

    localparam int PP_W = vtsi_pkg::MAG_W + vtsi_pkg::HALF_W;

    logic signed [vtsi_pkg::VEL_W-1:0] f_reg;
    logic [vtsi_pkg::MAG_W-1:0]        um_reg;
    logic                              negl_reg;
    logic [vtsi_pkg::PROD_W-1:0]       prod_reg;
    logic [vtsi_pkg::STAMP_W-1:0]      rem_reg;
    logic [vtsi_pkg::PROD_W-1:0]       quo_reg;

    logic signed [vtsi_pkg::MAG_W-1:0] delta;
    logic [vtsi_pkg::HALF_W-1:0]       mul_sel;
    logic [PP_W-1:0]                   pp;
    logic [vtsi_pkg::STAMP_W:0]        s1, s2, r1, r2, ud_x;
    logic                              ge1, ge2;
    logic                              q_big;
    logic [vtsi_pkg::Q_W-1:0]          qc;
    logic signed [vtsi_pkg::SUM_W-1:0] fs, qs, sum;
    logic signed [vtsi_pkg::VEL_W-1:0] sat;

    assign delta   = {g_in[vtsi_pkg::VEL_W-1], g_in} - {f_in[vtsi_pkg::VEL_W-1], f_in};
    assign mul_sel = ctrl.mul_hi ? uw[vtsi_pkg::STAMP_W-1:vtsi_pkg::HALF_W]
                                 : uw[vtsi_pkg::HALF_W-1:0];
    assign pp      = um_reg * mul_sel;

    // two quotient bits per step
    assign ud_x = {1'b0, ud};
    assign s1   = {rem_reg, prod_reg[vtsi_pkg::PROD_W-1]};
    assign ge1  = s1 >= ud_x;
    assign r1   = ge1 ? s1 - ud_x : s1;
    assign s2   = {r1[vtsi_pkg::STAMP_W-1:0], prod_reg[vtsi_pkg::PROD_W-2]};
    assign ge2  = s2 >= ud_x;
    assign r2   = ge2 ? s2 - ud_x : s2;

    assign q_big = quo_reg > vtsi_pkg::PROD_W'(vtsi_pkg::Q_LIMIT);
    assign qc    = q_big ? vtsi_pkg::Q_LIMIT : quo_reg[vtsi_pkg::Q_W-1:0];
    assign fs    = vtsi_pkg::SUM_W'(f_reg);
    assign qs    = $signed({1'b0, qc});
    assign sum   = (negl_reg ^ neg_s) ? fs - qs : fs + qs;

    always_comb
    begin
        if (!sum[vtsi_pkg::SUM_W-1] && (|sum[vtsi_pkg::SUM_W-2:vtsi_pkg::VEL_W-1]))
            sat = {1'b0, {(vtsi_pkg::VEL_W-1){1'b1}}};
        else if (sum[vtsi_pkg::SUM_W-1] && !(&sum[vtsi_pkg::SUM_W-2:vtsi_pkg::VEL_W-1]))
            sat = {1'b1, {(vtsi_pkg::VEL_W-1){1'b0}}};
        else
            sat = sum[vtsi_pkg::VEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            f_reg    <= f_in;
            um_reg   <= delta[vtsi_pkg::MAG_W-1] ? -delta : delta;
            negl_reg <= delta[vtsi_pkg::MAG_W-1];
        end
        if (ctrl.mul_lo)
            prod_reg <= vtsi_pkg::PROD_W'(pp);
        if (ctrl.mul_hi)
        begin
            prod_reg <= prod_reg + (vtsi_pkg::PROD_W'(pp) << vtsi_pkg::HALF_W);
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        if (ctrl.div_step)
        begin
            prod_reg <= prod_reg << 2;
            rem_reg  <= r2[vtsi_pkg::STAMP_W-1:0];
            quo_reg  <= {quo_reg[vtsi_pkg::PROD_W-3:0], ge1, ge2};
        end
        if (ctrl.finish)
            res <= eq ? f_reg : sat;
    end

endmodule
`default_nettype wire

// ----- src/velocity_time_sync_interpolator_core.sv -----
// top level: sample fifo, sync search sequencer and six interpolation lanes
//
// channel   signals                                   direction
// in        in_valid/in_ready, op, stamp, lin_*, ang_* request in
// out       out_valid/out_ready, status, out_stamp, out_* result out
// cfg       cfg_valid/cfg_ready, cfg_data              max_gap write
//
// a push goes from accept straight to the emit state, which loads the result register
// a query reads and compares one stamp pair at a time, then interpolates
//   (2 multiply passes, 41 divide steps at two bits each, finish, emit)
// reset clears pointers and fill count and sets max_gap to its reset value; memories are not cleared
// the next request is taken once the result sits in the output register
// a stalled output holds the sequencer in its emit state
`default_nettype none
module velocity_time_sync_interpolator_core #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                op,
    input  wire logic [vtsi_pkg::STAMP_W-1:0]        stamp,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0]   lin_x,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0]   lin_y,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0]   lin_z,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0]   ang_x,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0]   ang_y,
    input  wire logic signed [vtsi_pkg::VEL_W-1:0]   ang_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               status,
    output logic [vtsi_pkg::STAMP_W-1:0]             out_stamp,
    output logic signed [vtsi_pkg::VEL_W-1:0]        out_lin_x,
    output logic signed [vtsi_pkg::VEL_W-1:0]        out_lin_y,
    output logic signed [vtsi_pkg::VEL_W-1:0]        out_lin_z,
    output logic signed [vtsi_pkg::VEL_W-1:0]        out_ang_x,
    output logic signed [vtsi_pkg::VEL_W-1:0]        out_ang_y,
    output logic signed [vtsi_pkg::VEL_W-1:0]        out_ang_z,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [vtsi_pkg::GAP_W-1:0]          cfg_data
);

    localparam int ADDR_W = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(FIFO_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(FIFO_DEPTH);

    vtsi_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]            rd_reg, wr_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic [vtsi_pkg::GAP_W-1:0]   max_gap_reg;
    logic                         final_reg;
    logic [vtsi_pkg::STAMP_W-1:0] t_reg;
    logic [1:0]                   res_status_reg;
    logic [vtsi_pkg::CNT_W-1:0]   cnt_reg;
    logic [vtsi_pkg::STAMP_W-1:0] uw_reg, ud_reg;
    logic                         negs_reg, eq_reg;
    logic                         out_valid_reg;

    logic [vtsi_pkg::STAMP_W-1:0] st0, st1;
    logic [vtsi_pkg::ROW_W-1:0]   vel0, vel1;
    logic [vtsi_pkg::ROW_W-1:0]   wvel;
    logic [ADDR_W-1:0]            rd_plus;
    logic                         accept, slot_free, full, few;
    logic                         a_gt, b_lt, gap_bad;
    logic                         do_pop, do_final, do_interp, do_nosync;
    logic                         mem_we;
    logic signed [vtsi_pkg::STAMP_W:0] wb, dd;
    vtsi_pkg::lane_ctrl_t         lane_ctrl;
    logic signed [vtsi_pkg::VEL_W-1:0] lane_res [vtsi_pkg::AXES];

    assign in_ready  = (state_reg == vtsi_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign full      = (fill_reg == FULL_FILL);
    assign few       = (fill_reg < FILL_W'(2));
    assign rd_plus   = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
    assign mem_we    = accept && !op && !full;
    assign wvel      = {ang_z, ang_y, ang_x, lin_z, lin_y, lin_x};

    // pair compare on the stamps read from the two oldest slots
    assign a_gt    = st0 > t_reg;
    assign b_lt    = st1 < t_reg;
    assign gap_bad = ((t_reg - st0) > vtsi_pkg::STAMP_W'(max_gap_reg))
                  || ((st1 - t_reg) > vtsi_pkg::STAMP_W'(max_gap_reg));
    assign wb      = $signed({1'b0, t_reg}) - $signed({1'b0, st0});
    assign dd      = $signed({1'b0, st1}) - $signed({1'b0, st0});

    vtsi_mem #(
        .DEPTH   (FIFO_DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (wr_reg),
        .wstamp  (stamp),
        .wvel    (wvel),
        .raddr0  (rd_reg),
        .raddr1  (rd_plus),
        .rstamp0 (st0),
        .rstamp1 (st1),
        .rvel0   (vel0),
        .rvel1   (vel1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vtsi_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        do_pop     = 1'b0;
        do_final   = 1'b0;
        do_interp  = 1'b0;
        do_nosync  = 1'b0;
        lane_ctrl  = '0;
        case (state_reg)
            vtsi_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = op ? vtsi_pkg::S_RD : vtsi_pkg::S_EMIT;
            end
            vtsi_pkg::S_RD:
            begin
                // memory read of the two oldest slots is in flight
                if (few)
                begin
                    do_nosync  = 1'b1;
                    state_next = vtsi_pkg::S_EMIT;
                end
                else
                    state_next = vtsi_pkg::S_CMP;
            end
            vtsi_pkg::S_CMP:
            begin
                if (final_reg)
                    do_interp = 1'b1;
                else if (a_gt)
                    do_nosync = 1'b1;
                else if (b_lt)
                    do_pop = 1'b1;
                else if (gap_bad)
                begin
                    do_pop   = 1'b1;
                    do_final = 1'b1;
                end
                else
                    do_interp = 1'b1;
                if (do_interp)
                    state_next = vtsi_pkg::S_MUL_LO;
                else if (do_nosync)
                    state_next = vtsi_pkg::S_EMIT;
                else
                    state_next = vtsi_pkg::S_RD;
                lane_ctrl.load = do_interp;
            end
            vtsi_pkg::S_MUL_LO:
            begin
                lane_ctrl.mul_lo = 1'b1;
                state_next       = vtsi_pkg::S_MUL_HI;
            end
            vtsi_pkg::S_MUL_HI:
            begin
                lane_ctrl.mul_hi = 1'b1;
                state_next       = vtsi_pkg::S_DIV;
            end
            vtsi_pkg::S_DIV:
            begin
                lane_ctrl.div_step = 1'b1;
                if (cnt_reg == vtsi_pkg::CNT_W'(vtsi_pkg::DIV_STEPS - 1))
                    state_next = vtsi_pkg::S_FIN;
            end
            vtsi_pkg::S_FIN:
            begin
                lane_ctrl.finish = 1'b1;
                state_next       = vtsi_pkg::S_EMIT;
            end
            vtsi_pkg::S_EMIT:
            begin
                if (slot_free)
                    state_next = vtsi_pkg::S_IDLE;
            end
            default:
                state_next = vtsi_pkg::S_IDLE;
        endcase
    end

    // control state: pointers, fill, register, result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg        <= '0;
            wr_reg        <= '0;
            fill_reg      <= '0;
            max_gap_reg   <= vtsi_pkg::GAP_RESET;
            final_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_gap_reg <= cfg_data;
            if (mem_we)
            begin
                wr_reg   <= (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg   <= rd_plus;
                fill_reg <= fill_reg - 1'b1;
            end
            if (accept)
                final_reg <= 1'b0;
            else if (do_final)
                final_reg <= 1'b1;
            if (state_reg == vtsi_pkg::S_DIV)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (state_reg == vtsi_pkg::S_EMIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg          <= stamp;
            res_status_reg <= full ? vtsi_pkg::STATUS_FULL : vtsi_pkg::STATUS_STORED;
        end
        if (do_nosync)
            res_status_reg <= vtsi_pkg::STATUS_NO_SYNC;
        if (lane_ctrl.finish)
            res_status_reg <= vtsi_pkg::STATUS_SYNCED;
        if (do_interp)
        begin
            uw_reg   <= wb[vtsi_pkg::STAMP_W] ? vtsi_pkg::STAMP_W'(-wb)
                                              : wb[vtsi_pkg::STAMP_W-1:0];
            ud_reg   <= dd[vtsi_pkg::STAMP_W] ? vtsi_pkg::STAMP_W'(-dd)
                                              : dd[vtsi_pkg::STAMP_W-1:0];
            negs_reg <= wb[vtsi_pkg::STAMP_W] ^ dd[vtsi_pkg::STAMP_W];
            eq_reg   <= (st0 == st1);
        end
        if (state_reg == vtsi_pkg::S_EMIT && slot_free)
        begin
            status <= res_status_reg;
            if (res_status_reg == vtsi_pkg::STATUS_SYNCED)
            begin
                out_stamp <= t_reg;
                out_lin_x <= lane_res[0];
                out_lin_y <= lane_res[1];
                out_lin_z <= lane_res[2];
                out_ang_x <= lane_res[3];
                out_ang_y <= lane_res[4];
                out_ang_z <= lane_res[5];
            end
            else
            begin
                out_stamp <= '0;
                out_lin_x <= '0;
                out_lin_y <= '0;
                out_lin_z <= '0;
                out_ang_x <= '0;
                out_ang_y <= '0;
                out_ang_z <= '0;
            end
        end
    end

    // one lane per axis, older sample in port 0
    for (genvar j = 0; j < vtsi_pkg::AXES; j++)
    begin : g_lane
        vtsi_lane u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .f_in  (vel0[j*vtsi_pkg::VEL_W +: vtsi_pkg::VEL_W]),
            .g_in  (vel1[j*vtsi_pkg::VEL_W +: vtsi_pkg::VEL_W]),
            .uw    (uw_reg),
            .ud    (ud_reg),
            .neg_s (negs_reg),
            .eq    (eq_reg),
            .res   (lane_res[j])
        );
    end

endmodule
`default_nettype wire

// ----- src/vtsi_checker.sv -----
// port-level checker for the interpolator top level, with its bind
`default_nettype none
module vtsi_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [1:0]                        status,
    input wire logic [vtsi_pkg::STAMP_W-1:0]      out_stamp,
    input wire logic signed [vtsi_pkg::VEL_W-1:0] out_lin_x,
    input wire logic signed [vtsi_pkg::VEL_W-1:0] out_ang_z
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_stamp))
        else $error("stalled result changed");

    // only a synced result carries data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != vtsi_pkg::STATUS_SYNCED
        |-> out_stamp == '0 && out_lin_x == '0 && out_ang_z == '0)
        else $error("unsynced result carries data");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a result appears only after some request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready || $past(!in_ready))
        else $error("result without request");

endmodule

bind velocity_time_sync_interpolator_core vtsi_checker u_vtsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_stamp (out_stamp),
    .out_lin_x (out_lin_x),
    .out_ang_z (out_ang_z)
);
`default_nettype wire

// ----- test/velocity_time_sync_interpolator_core_tb.sv -----
// testbench for the velocity time-sync interpolator core: scoreboard, stimulus and checks
`timescale 1ns / 1ps
`default_nettype none
module velocity_time_sync_interpolator_core_tb;

    localparam int DEPTH = 16;
    localparam logic [vtsi_pkg::STAMP_W-1:0] STAMP_MAX = {vtsi_pkg::STAMP_W{1'b1}};

    typedef logic signed [vtsi_pkg::VEL_W-1:0] axes_t [vtsi_pkg::AXES];

    typedef struct {
        logic [1:0]                   status;
        logic [vtsi_pkg::STAMP_W-1:0] stamp;
        axes_t                        vel;
    } sync_result_t;

    // fifo mirror plus the max_gap setting; every request yields one result
    class sync_scoreboard;
        logic [vtsi_pkg::STAMP_W-1:0] stamps [DEPTH];
        axes_t                        rows [DEPTH];
        int                           rd_slot;
        int                           wr_slot;
        int                           fill;
        logic [vtsi_pkg::GAP_W-1:0]   gap;
        sync_result_t                 pending [$];
        int                           errors;
        int                           n_synced;
        int                           n_missed;
        int                           n_dropped;

        function new();
            gap = vtsi_pkg::GAP_RESET;
        endfunction

        function void queue_result(sync_result_t r);
            pending = {pending, r};
        endfunction

        // f + trunc((g - f) * (t - a) / (b - a)), quotient clamped, sum saturated
        function logic signed [vtsi_pkg::VEL_W-1:0] lerp(
                logic signed [vtsi_pkg::VEL_W-1:0] f,
                logic signed [vtsi_pkg::VEL_W-1:0] g, logic [vtsi_pkg::STAMP_W-1:0] a,
                logic [vtsi_pkg::STAMP_W-1:0] b, logic [vtsi_pkg::STAMP_W-1:0] t);
            longint     delta;
            longint     wb;
            longint     d;
            longint     res;
            logic [63:0]  um;
            logic [63:0]  uw;
            logic [63:0]  ud;
            logic [127:0] q;
            bit         neg;
            if (a == b)
                return f;
            delta = longint'(g) - longint'(f);
            wb = longint'(t) - longint'(a);
            d = longint'(b) - longint'(a);
            neg = (delta < 0) ^ (wb < 0) ^ (d < 0);
            um = delta < 0 ? -delta : delta;
            uw = wb < 0 ? -wb : wb;
            ud = d < 0 ? -d : d;
            q = ({64'b0, um} * {64'b0, uw}) / {64'b0, ud};
            if (q > 128'h4_0000_0000)
                q = 128'h4_0000_0000;
            res = longint'(f) + (neg ? -longint'(q[63:0]) : longint'(q[63:0]));
            if (res > 64'sd2147483647)
                res = 64'sd2147483647;
            if (res < -64'sd2147483648)
                res = -64'sd2147483648;
            return res[vtsi_pkg::VEL_W-1:0];
        endfunction

        function void note_request(bit is_query, logic [vtsi_pkg::STAMP_W-1:0] t, axes_t v);
            sync_result_t r;
            logic [vtsi_pkg::STAMP_W-1:0] a;
            logic [vtsi_pkg::STAMP_W-1:0] b;
            int nx;
            r.status = vtsi_pkg::STATUS_NO_SYNC;
            r.stamp = '0;
            foreach (r.vel[j])
                r.vel[j] = '0;
            if (!is_query) begin
                if (fill >= DEPTH) begin
                    r.status = vtsi_pkg::STATUS_FULL;
                    n_dropped++;
                end else begin
                    stamps[wr_slot] = t;
                    rows[wr_slot] = v;
                    wr_slot = (wr_slot + 1) % DEPTH;
                    fill++;
                    r.status = vtsi_pkg::STATUS_STORED;
                end
                queue_result(r);
                return;
            end
            // search for a bracketing pair
            while (fill >= 2) begin
                a = stamps[rd_slot];
                b = stamps[(rd_slot + 1) % DEPTH];
                if (a > t) begin
                    n_missed++;
                    queue_result(r);
                    return;
                end
                if (b < t) begin
                    rd_slot = (rd_slot + 1) % DEPTH;
                    fill--;
                    continue;
                end
                if (t - a > gap || b - t > gap) begin
                    rd_slot = (rd_slot + 1) % DEPTH;
                    fill--;
                end
                break;
            end
            if (fill < 2) begin
                n_missed++;
                queue_result(r);
                return;
            end
            nx = (rd_slot + 1) % DEPTH;
            r.status = vtsi_pkg::STATUS_SYNCED;
            r.stamp = t;
            foreach (r.vel[j])
                r.vel[j] = lerp(rows[rd_slot][j], rows[nx][j], stamps[rd_slot], stamps[nx], t);
            n_synced++;
            queue_result(r);
        endfunction

        function void check_result(sync_result_t got);
            sync_result_t exp;
            string axis_names [vtsi_pkg::AXES] = '{"out_lin_x", "out_lin_y", "out_lin_z",
                                                   "out_ang_x", "out_ang_y", "out_ang_z"};
            if (pending.size() == 0) begin
                $error("result with nothing pending: status %0d", got.status);
                errors++;
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.stamp !== exp.stamp) begin
                $error("out_stamp: expected %0d, got %0d", exp.stamp, got.stamp);
                errors++;
            end
            foreach (exp.vel[j])
                if (got.vel[j] !== exp.vel[j]) begin
                    $error("%s: expected %0d, got %0d", axis_names[j], exp.vel[j], got.vel[j]);
                    errors++;
                end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic                                op;
    logic [vtsi_pkg::STAMP_W-1:0]        stamp;
    logic signed [vtsi_pkg::VEL_W-1:0]   lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;
    logic                                out_valid;
    logic                                out_ready;
    logic [1:0]                          status;
    logic [vtsi_pkg::STAMP_W-1:0]        out_stamp;
    logic signed [vtsi_pkg::VEL_W-1:0]   out_lin_x, out_lin_y, out_lin_z;
    logic signed [vtsi_pkg::VEL_W-1:0]   out_ang_x, out_ang_y, out_ang_z;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [vtsi_pkg::GAP_W-1:0]          cfg_data;

    sync_scoreboard sb;
    bit             steady;      // no idling on either side
    bit             hold_req;    // receiver holds off for a long stretch
    int             n_requests;
    logic [vtsi_pkg::STAMP_W-1:0] now_us;  // running sample time for well-formed streams

    velocity_time_sync_interpolator_core #(.FIFO_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .stamp(stamp),
        .lin_x(lin_x), .lin_y(lin_y), .lin_z(lin_z),
        .ang_x(ang_x), .ang_y(ang_y), .ang_z(ang_z),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .out_stamp(out_stamp),
        .out_lin_x(out_lin_x), .out_lin_y(out_lin_y), .out_lin_z(out_lin_z),
        .out_ang_x(out_ang_x), .out_ang_y(out_ang_y), .out_ang_z(out_ang_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // generous run limit
    initial begin
        #(12 * 4000000);
        $display("Test completed with failures");
        $finish;
    end

    // one request on the input channel, optionally preceded by an idle gap
    task automatic send_request(bit is_query, logic [vtsi_pkg::STAMP_W-1:0] s, axes_t v);
        if (!steady && $urandom_range(0, 99) < 13) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= is_query;
        stamp <= s;
        lin_x <= v[0];
        lin_y <= v[1];
        lin_z <= v[2];
        ang_x <= v[3];
        ang_y <= v[4];
        ang_z <= v[5];
        do @(posedge clk); while (!in_ready);
        sb.note_request(is_query, s, v);
        n_requests++;
    endtask

    function automatic axes_t rand_axes();
        axes_t v;
        foreach (v[j])
            v[j] = $urandom;
        return v;
    endfunction

    task automatic push_sample(logic [vtsi_pkg::STAMP_W-1:0] s, axes_t v);
        send_request(1'b0, s, v);
    endtask

    task automatic sync_query(logic [vtsi_pkg::STAMP_W-1:0] s);
        send_request(1'b1, s, rand_axes());
    endtask

    // sender pauses until every pending result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gap(logic [vtsi_pkg::GAP_W-1:0] g);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= g;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.gap = g;
    endtask

    // mostly well-formed streams with rising stamps, some disorder and noise
    task automatic random_phase(int count, int span);
        int r;
        logic [vtsi_pkg::STAMP_W-1:0] t;
        logic [vtsi_pkg::STAMP_W-1:0] back;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                t = vtsi_pkg::STAMP_W'({$urandom, $urandom});
                send_request(1'($urandom_range(0, 1)), t, rand_axes());
            end else if (r < 56) begin
                case ($urandom_range(0, 9))
                    0: t = now_us;                              // equal stamps
                    1: t = now_us - vtsi_pkg::STAMP_W'($urandom_range(0, span)); // out of order
                    default: begin
                        now_us += vtsi_pkg::STAMP_W'($urandom_range(1, span));
                        t = now_us;
                    end
                endcase
                push_sample(t, rand_axes());
            end else begin
                back = vtsi_pkg::STAMP_W'($urandom_range(0, 3 * span));
                if ($urandom_range(0, 4) == 0)
                    t = now_us + vtsi_pkg::STAMP_W'($urandom_range(0, span));
                else
                    t = now_us - back;
                sync_query(t);
            end
        end
    endtask

    // directed corner cases
    task automatic directed_phase();
        axes_t lo;
        axes_t hi;
        foreach (lo[j]) begin
            lo[j] = 32'sh8000_0000;
            hi[j] = 32'sh7fff_ffff;
        end
        sync_query(48'd0);                 // empty fifo
        push_sample(48'd0, lo);
        sync_query(48'd0);                 // only one sample held
        push_sample(48'd0, hi);
        sync_query(48'd0);                 // equal stamps give the older sample
        sync_query(STAMP_MAX);             // pops down to one sample
        // gap pop followed by backward extrapolation that saturates
        push_sample(48'd1000, lo);
        push_sample(48'd301000, lo);
        push_sample(48'd301010, hi);
        sync_query(48'd251000);
        sync_query(48'd301005);            // plain interpolation, extremes
        sync_query(48'd500);               // front newer than target
        // fill to the brim and beyond
        for (int k = 0; k < DEPTH + 1; k++)
            push_sample(48'd301020 + 48'(k * 10), rand_axes());
        sync_query(STAMP_MAX);             // drain
        now_us = 48'd400000;
    endtask

    // receiver: checks results and stalls at random
    initial begin
        sync_result_t got;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.status = status;
                got.stamp = out_stamp;
                got.vel = '{out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z};
                sb.check_result(got);
            end
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 13);
        end
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = 1'b0;
        stamp = '0;
        {lin_x, lin_y, lin_z, ang_x, ang_y, ang_z} = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        steady = 1'b0;
        hold_req = 1'b0;
        n_requests = 0;
        now_us = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_phase();
        random_phase(300, 60000);          // reset value of max_gap

        write_gap('0);                     // zero max_gap, smallest window
        random_phase(250, 3);

        write_gap({vtsi_pkg::GAP_W{1'b1}}); // widest window, no idling
        steady = 1'b1;
        random_phase(300, 2000000);
        steady = 1'b0;

        write_gap(vtsi_pkg::GAP_W'($urandom));
        hold_req = 1'b1;                   // long receiver stall while requests keep coming
        random_phase(400, 100000);

        write_gap(vtsi_pkg::GAP_RESET);
        random_phase(450, 60000);

        drain_results();
        repeat (100) @(posedge clk);
        $display("covered %0d requests: %0d synced, %0d not synced, %0d dropped pushes",
                 n_requests, sb.n_synced, sb.n_missed, sb.n_dropped);
        $display("max_gap phases: reset value, zero, full scale, random, reset value again");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
src/vtsi_pkg.sv
src/vtsi_mem.sv
src/vtsi_lane.sv
src/velocity_time_sync_interpolator_core.sv
src/vtsi_checker.sv
test/velocity_time_sync_interpolator_core_tb.sv
